// ===== rtl/cspe_pkg.sv =====
package cspe_pkg;

    // fixed field widths
    localparam int T_W         = 17;
    localparam int COORD_W     = 32;
    localparam int MUL_W       = 35;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int ACC_W       = 68;
    localparam int WACC_W      = 56;
    localparam int WEIGHT_W    = 33;
    localparam int WEIGHT_FRAC = 28;
    localparam int RED_W       = 10;
    localparam int SQ_W        = 67;
    localparam int ROOT_W      = 32;
    localparam int LEN_W       = 33;

    localparam logic [T_W-1:0]   T_ONE   = 17'h10000;
    localparam logic [LEN_W-1:0] LEN_MAX = 33'h0_FFFF_FFFF;

    // curve modes
    localparam logic [1:0] MODE_LINEAR  = 2'd0;
    localparam logic [1:0] MODE_CATMULL = 2'd1;
    localparam logic [1:0] MODE_BEZIER  = 2'd2;
    localparam logic [1:0] MODE_UNUSED  = 2'd3;

    // item operations
    localparam logic [1:0] OP_LOAD     = 2'd0;
    localparam logic [1:0] OP_POSITION = 2'd1;
    localparam logic [1:0] OP_DERIV    = 2'd2;
    localparam logic [1:0] OP_LENGTH   = 2'd3;

    // register indexes
    localparam logic [1:0] REG_CURVE_MODE = 2'd0;
    localparam logic [1:0] REG_SEG_LOW    = 2'd1;
    localparam logic [1:0] REG_SEG_HIGH   = 2'd2;

    typedef struct packed {
        logic [1:0]                op;
        logic [7:0]                slot;
        logic [T_W-1:0]            param_t;
        logic signed [COORD_W-1:0] load_x;
        logic signed [COORD_W-1:0] load_y;
        logic signed [COORD_W-1:0] load_z;
    } in_item_t;

    typedef struct packed {
        logic signed [COORD_W-1:0] out_x;
        logic signed [COORD_W-1:0] out_y;
        logic signed [COORD_W-1:0] out_z;
        logic [31:0]               seg_length;
        logic                      range_error;
    } out_item_t;

    typedef struct packed {
        logic [1:0] curve_mode;
        logic [7:0] segment_low;
        logic [7:0] segment_high;
    } cfg_t;

    // basis rows t^3, t^2, t, 1; columns point 0..3 (catmull-rom doubled)
    localparam logic signed [3:0] BASIS [0:2][0:3][0:3] = '{
        '{'{4'sd0, 4'sd0, 4'sd0, 4'sd0}, '{4'sd0, 4'sd0, 4'sd0, 4'sd0},
          '{-4'sd1, 4'sd1, 4'sd0, 4'sd0}, '{4'sd1, 4'sd0, 4'sd0, 4'sd0}},
        '{'{-4'sd1, 4'sd3, -4'sd3, 4'sd1}, '{4'sd2, -4'sd5, 4'sd4, -4'sd1},
          '{-4'sd1, 4'sd0, 4'sd1, 4'sd0}, '{4'sd0, 4'sd2, 4'sd0, 4'sd0}},
        '{'{-4'sd1, 4'sd3, -4'sd3, 4'sd1}, '{4'sd3, -4'sd6, 4'sd3, 4'sd0},
          '{-4'sd3, 4'sd3, 4'sd0, 4'sd0}, '{4'sd1, 4'sd0, 4'sd0, 4'sd0}}
    };

    // one basis weight in signed q.28, rounded half away from zero
    function automatic logic signed [WEIGHT_W-1:0] calc_weight(
        input logic [1:0]     mode,
        input logic [1:0]     k,
        input logic           deriv,
        input logic [T_W-1:0] t,
        input logic [33:0]    t2,
        input logic [50:0]    t3
    );
        logic signed [WACC_W-1:0] tv [4];
        logic signed [WACC_W-1:0] acc;
        logic signed [WACC_W-1:0] res;
        logic signed [3:0]        coef;
        logic [WACC_W-1:0]        mag;
        logic [WACC_W-1:0]        rnd;
        logic [4:0]               sh;
        acc = '0;
        if (!deriv) begin
            tv[0] = $signed(WACC_W'(t3));
            tv[1] = $signed(WACC_W'({t2, 16'b0}));
            tv[2] = $signed(WACC_W'({t, 32'b0}));
            tv[3] = $signed(WACC_W'(1) << 48);
            sh    = 5'd20;
        end else begin
            tv[0] = $signed(WACC_W'({t2, 1'b0}) + WACC_W'(t2));
            tv[1] = $signed(WACC_W'({t, 17'b0}));
            tv[2] = $signed(WACC_W'(1) << 32);
            tv[3] = '0;
            sh    = 5'd4;
        end
        if (mode == MODE_CATMULL) begin
            sh = sh + 5'd1;
        end
        for (int r = 0; r < 4; r++) begin
            coef = (mode == MODE_UNUSED) ? 4'sd0 : BASIS[mode][r][k];
            acc  = acc + coef * tv[r];
        end
        mag = acc[WACC_W-1] ? WACC_W'(-acc) : WACC_W'(acc);
        rnd = (mag + (WACC_W'(1) << (sh - 5'd1))) >> sh;
        res = acc[WACC_W-1] ? -$signed(rnd) : $signed(rnd);
        return WEIGHT_W'(res);
    endfunction

    // drop the weight fraction, round half away from zero, saturate to 32 bits
    function automatic logic signed [COORD_W-1:0] round_sat(
        input logic signed [ACC_W-1:0] v
    );
        logic [ACC_W-1:0]        mag;
        logic [ACC_W-1:0]        rnd;
        logic signed [ACC_W-1:0] res;
        logic signed [COORD_W-1:0] out;
        mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
        rnd = (mag + (ACC_W'(1) << (WEIGHT_FRAC - 1))) >> WEIGHT_FRAC;
        res = v[ACC_W-1] ? -$signed(rnd) : $signed(rnd);
        if (res[ACC_W-1:COORD_W-1] == '0 || res[ACC_W-1:COORD_W-1] == '1) begin
            out = res[COORD_W-1:0];
        end else if (res[ACC_W-1]) begin
            out = {1'b1, {(COORD_W-1){1'b0}}};
        end else begin
            out = {1'b0, {(COORD_W-1){1'b1}}};
        end
        return out;
    endfunction

endpackage

// ===== rtl/cspe_point_store.sv =====
module cspe_point_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [95:0]   wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [95:0]   rd_data
);

    logic [95:0] mem [DEPTH];

    // one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/cspe_mul.sv =====
module cspe_mul (
    input  logic                                   aclk,
    input  logic signed [cspe_pkg::MUL_W-1:0]      op_a,
    input  logic signed [cspe_pkg::MUL_W-1:0]      op_b,
    output logic signed [cspe_pkg::PROD_W-1:0]     prod
);
    import cspe_pkg::*;

    // shared signed multiplier, product registered
    always_ff @(posedge aclk) begin
        prod <= op_a * op_b;
    end

endmodule

// ===== rtl/cspe_core.sv =====
module cspe_core #(
    parameter int MAX_POINTS   = 256,
    parameter int LENGTH_STEPS = 3
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  cspe_pkg::in_item_t  in_item,
    input  cspe_pkg::cfg_t      cfg,
    output logic                res_valid,
    input  logic                res_ready,
    output cspe_pkg::out_item_t res_item
);
    import cspe_pkg::*;

    localparam int AW     = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int I_W    = $clog2(LENGTH_STEPS + 1);
    localparam int REM_W  = $clog2(2 * LENGTH_STEPS) + 1;
    localparam int STEP_Q = 65536 / LENGTH_STEPS;
    localparam int STEP_R = 65536 % LENGTH_STEPS;
    localparam int HALF   = LENGTH_STEPS / 2;

    typedef enum logic [4:0] {
        ST_IDLE, ST_REDUCE, ST_T2, ST_T3, ST_TC, ST_W, ST_MX, ST_MY, ST_MZ,
        ST_AZ, ST_FIN, ST_CX, ST_CY, ST_CZ, ST_CS, ST_SQM, ST_SQC, ST_CADD,
        ST_CNEXT, ST_DONE
    } state_t;

    state_t                    state_reg;
    in_item_t                  item_reg;
    logic [1:0]                mode_reg;
    logic                      err_reg;
    logic [RED_W-1:0]          red_reg;
    logic [AW-1:0]             ptr_start_reg;
    logic [AW-1:0]             ptr_reg;
    logic [1:0]                k_reg;
    logic [T_W-1:0]            t_reg;
    logic [33:0]               t2_reg;
    logic [50:0]               t3_reg;
    logic signed [WEIGHT_W-1:0] w_reg;
    logic signed [ACC_W-1:0]   acc_x_reg, acc_y_reg, acc_z_reg;
    logic signed [COORD_W-1:0] res_x_reg, res_y_reg, res_z_reg;
    logic signed [COORD_W-1:0] prev_x_reg, prev_y_reg, prev_z_reg;
    logic [SQ_W-1:0]           sq_reg;
    logic [ROOT_W-1:0]         root_reg;
    logic [4:0]                bit_reg;
    logic [LEN_W-1:0]          total_reg;
    logic [I_W-1:0]            i_reg;
    logic [T_W-1:0]            tq_reg;
    logic [REM_W-1:0]          trem_reg;

    logic signed [MUL_W-1:0]   mul_a, mul_b;
    logic signed [PROD_W-1:0]  mul_prod;
    logic                      mem_we, mem_re;
    logic [95:0]               mem_rdata;
    logic signed [COORD_W-1:0] rd_x, rd_y, rd_z;

    logic [RED_W-1:0]          eff_idx;
    logic                      idx_bad;
    logic [AW-1:0]             base;
    logic                      last_k;
    logic [I_W-1:0]            steps;
    logic [T_W-1:0]            tq_adv;
    logic [REM_W-1:0]          trem_adv;
    logic signed [COORD_W:0]   dx, dy, dz;
    logic [COORD_W:0]          ax, ay, az;
    logic [SQ_W-1:0]           sq_sum;
    logic [ROOT_W-1:0]         cand;
    logic [LEN_W:0]            len_sum;
    logic signed [COORD_W-1:0] fin_x, fin_y, fin_z;

    assign rd_x = mem_rdata[95:64];
    assign rd_y = mem_rdata[63:32];
    assign rd_z = mem_rdata[31:0];

    // effective segment index and range check at the input
    assign eff_idx = (cfg.curve_mode == MODE_BEZIER)
                   ? RED_W'({in_item.slot, 1'b0}) + RED_W'(in_item.slot)
                   : RED_W'(in_item.slot);
    assign idx_bad = (cfg.curve_mode == MODE_UNUSED)
                  || (eff_idx < RED_W'(cfg.segment_low))
                  || (eff_idx >= RED_W'(cfg.segment_high));

    assign base   = AW'(red_reg);
    assign last_k = (mode_reg == MODE_LINEAR) ? (k_reg == 2'd1) : (k_reg == 2'd3);
    assign steps  = (mode_reg == MODE_LINEAR) ? I_W'(1) : I_W'(LENGTH_STEPS);

    // next sample parameter, kept as quotient and remainder
    always_comb begin
        tq_adv   = tq_reg + T_W'(STEP_Q);
        trem_adv = trem_reg + REM_W'(STEP_R);
        if (trem_adv >= REM_W'(LENGTH_STEPS)) begin
            trem_adv = trem_adv - REM_W'(LENGTH_STEPS);
            tq_adv   = tq_adv + T_W'(1);
        end
        if (mode_reg == MODE_LINEAR) begin
            tq_adv = T_ONE;
        end
    end

    // chord terms
    assign dx = COORD_W'(res_x_reg) - COORD_W'(prev_x_reg) == 0 ? '0
              : (COORD_W+1)'(res_x_reg) - (COORD_W+1)'(prev_x_reg);
    assign dy = (COORD_W+1)'(res_y_reg) - (COORD_W+1)'(prev_y_reg);
    assign dz = (COORD_W+1)'(res_z_reg) - (COORD_W+1)'(prev_z_reg);
    assign ax = dx[COORD_W] ? (COORD_W+1)'(-dx) : (COORD_W+1)'(dx);
    assign ay = dy[COORD_W] ? (COORD_W+1)'(-dy) : (COORD_W+1)'(dy);
    assign az = dz[COORD_W] ? (COORD_W+1)'(-dz) : (COORD_W+1)'(dz);
    assign sq_sum  = sq_reg + SQ_W'($unsigned(mul_prod[65:0]));
    assign cand    = root_reg | (ROOT_W'(1) << bit_reg);
    assign len_sum = (LEN_W+1)'(total_reg) + (LEN_W+1)'(root_reg);

    assign fin_x = round_sat(acc_x_reg);
    assign fin_y = round_sat(acc_y_reg);
    assign fin_z = round_sat(acc_z_reg);

    // multiplier operand and memory port selection
    always_comb begin
        mul_a  = '0;
        mul_b  = '0;
        mem_we = 1'b0;
        mem_re = 1'b0;
        case (state_reg)
            ST_T2: begin
                mul_a = $signed(MUL_W'(t_reg));
                mul_b = $signed(MUL_W'(t_reg));
            end
            ST_T3: begin
                mul_a = $signed(MUL_W'(mul_prod[33:0]));
                mul_b = $signed(MUL_W'(t_reg));
            end
            ST_W: begin
                mem_re = 1'b1;
            end
            ST_MX: begin
                mul_a = MUL_W'(w_reg);
                mul_b = MUL_W'(rd_x);
            end
            ST_MY: begin
                mul_a = MUL_W'(w_reg);
                mul_b = MUL_W'(rd_y);
            end
            ST_MZ: begin
                mul_a = MUL_W'(w_reg);
                mul_b = MUL_W'(rd_z);
            end
            ST_CX: begin
                mul_a = $signed(MUL_W'(ax));
                mul_b = $signed(MUL_W'(ax));
            end
            ST_CY: begin
                mul_a = $signed(MUL_W'(ay));
                mul_b = $signed(MUL_W'(ay));
            end
            ST_CZ: begin
                mul_a = $signed(MUL_W'(az));
                mul_b = $signed(MUL_W'(az));
            end
            ST_SQM: begin
                mul_a = $signed(MUL_W'(cand));
                mul_b = $signed(MUL_W'(cand));
            end
            ST_REDUCE: begin
                mem_we = (item_reg.op == OP_LOAD) && (int'(red_reg) < MAX_POINTS);
            end
            default: begin
            end
        endcase
    end

    cspe_mul u_mul (
        .aclk (aclk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_prod)
    );

    cspe_point_store #(
        .DEPTH (MAX_POINTS),
        .AW    (AW)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (base),
        .wr_data ({item_reg.load_x, item_reg.load_y, item_reg.load_z}),
        .rd_en   (mem_re),
        .rd_addr (ptr_reg),
        .rd_data (mem_rdata)
    );

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (in_valid) begin
                        item_reg <= in_item;
                        mode_reg <= cfg.curve_mode;
                        t_reg    <= (in_item.param_t > T_ONE) ? T_ONE : in_item.param_t;
                        err_reg  <= 1'b0;
                        if (in_item.op == OP_LOAD) begin
                            red_reg   <= RED_W'(in_item.slot);
                            state_reg <= ST_REDUCE;
                        end else if (idx_bad) begin
                            err_reg   <= 1'b1;
                            state_reg <= ST_DONE;
                        end else begin
                            red_reg   <= eff_idx;
                            state_reg <= ST_REDUCE;
                        end
                    end
                end
                // address modulo the store depth, one subtraction a cycle
                ST_REDUCE: begin
                    if (int'(red_reg) >= MAX_POINTS) begin
                        red_reg <= red_reg - RED_W'(MAX_POINTS);
                    end else if (item_reg.op == OP_LOAD) begin
                        state_reg <= ST_IDLE;
                    end else begin
                        if (mode_reg == MODE_CATMULL) begin
                            ptr_start_reg <= (base == '0) ? AW'(MAX_POINTS - 1)
                                                          : base - AW'(1);
                        end else begin
                            ptr_start_reg <= base;
                        end
                        if (item_reg.op == OP_LENGTH) begin
                            t_reg     <= '0;
                            tq_reg    <= '0;
                            trem_reg  <= REM_W'(HALF);
                            i_reg     <= '0;
                            total_reg <= '0;
                        end
                        state_reg <= ST_T2;
                    end
                end
                ST_T2: begin
                    acc_x_reg <= '0;
                    acc_y_reg <= '0;
                    acc_z_reg <= '0;
                    k_reg     <= '0;
                    ptr_reg   <= ptr_start_reg;
                    state_reg <= ST_T3;
                end
                ST_T3: begin
                    t2_reg    <= mul_prod[33:0];
                    state_reg <= ST_TC;
                end
                ST_TC: begin
                    t3_reg    <= mul_prod[50:0];
                    state_reg <= ST_W;
                end
                ST_W: begin
                    w_reg <= calc_weight(mode_reg, k_reg, item_reg.op == OP_DERIV,
                                         t_reg, t2_reg, t3_reg);
                    state_reg <= ST_MX;
                end
                ST_MX: begin
                    state_reg <= ST_MY;
                end
                ST_MY: begin
                    acc_x_reg <= acc_x_reg + ACC_W'(mul_prod);
                    state_reg <= ST_MZ;
                end
                ST_MZ: begin
                    acc_y_reg <= acc_y_reg + ACC_W'(mul_prod);
                    state_reg <= ST_AZ;
                end
                ST_AZ: begin
                    acc_z_reg <= acc_z_reg + ACC_W'(mul_prod);
                    k_reg     <= k_reg + 2'd1;
                    ptr_reg   <= (ptr_reg == AW'(MAX_POINTS - 1)) ? '0 : ptr_reg + AW'(1);
                    state_reg <= last_k ? ST_FIN : ST_W;
                end
                ST_FIN: begin
                    res_x_reg <= fin_x;
                    res_y_reg <= fin_y;
                    res_z_reg <= fin_z;
                    if (item_reg.op != OP_LENGTH) begin
                        state_reg <= ST_DONE;
                    end else if (i_reg == '0) begin
                        prev_x_reg <= fin_x;
                        prev_y_reg <= fin_y;
                        prev_z_reg <= fin_z;
                        i_reg      <= I_W'(1);
                        tq_reg     <= tq_adv;
                        trem_reg   <= trem_adv;
                        t_reg      <= tq_adv;
                        state_reg  <= ST_T2;
                    end else begin
                        state_reg <= ST_CX;
                    end
                end
                ST_CX: begin
                    state_reg <= ST_CY;
                end
                ST_CY: begin
                    sq_reg    <= SQ_W'($unsigned(mul_prod[65:0]));
                    state_reg <= ST_CZ;
                end
                ST_CZ: begin
                    sq_reg    <= sq_sum;
                    state_reg <= ST_CS;
                end
                ST_CS: begin
                    sq_reg <= sq_sum;
                    if (sq_sum[SQ_W-1:64] != '0) begin
                        total_reg <= LEN_MAX;
                        state_reg <= ST_CNEXT;
                    end else begin
                        root_reg  <= '0;
                        bit_reg   <= 5'd31;
                        state_reg <= ST_SQM;
                    end
                end
                // square root, one result bit per pass through ST_SQM and ST_SQC
                ST_SQM: begin
                    state_reg <= ST_SQC;
                end
                ST_SQC: begin
                    if (SQ_W'($unsigned(mul_prod[65:0])) <= sq_reg) begin
                        root_reg <= cand;
                    end
                    if (bit_reg == '0) begin
                        state_reg <= ST_CADD;
                    end else begin
                        bit_reg   <= bit_reg - 5'd1;
                        state_reg <= ST_SQM;
                    end
                end
                ST_CADD: begin
                    total_reg <= (len_sum > (LEN_W+1)'(LEN_MAX)) ? LEN_MAX
                                                                 : LEN_W'(len_sum);
                    state_reg <= ST_CNEXT;
                end
                ST_CNEXT: begin
                    prev_x_reg <= res_x_reg;
                    prev_y_reg <= res_y_reg;
                    prev_z_reg <= res_z_reg;
                    if (i_reg == steps) begin
                        state_reg <= ST_DONE;
                    end else begin
                        i_reg     <= i_reg + I_W'(1);
                        tq_reg    <= tq_adv;
                        trem_reg  <= trem_adv;
                        t_reg     <= tq_adv;
                        state_reg <= ST_T2;
                    end
                end
                ST_DONE: begin
                    if (res_ready) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);

    // result beat
    always_comb begin
        res_item = '0;
        if (err_reg) begin
            res_item.range_error = 1'b1;
        end else if (item_reg.op == OP_LENGTH) begin
            res_item.seg_length = total_reg[31:0];
        end else begin
            res_item.out_x = res_x_reg;
            res_item.out_y = res_y_reg;
            res_item.out_z = res_z_reg;
        end
    end

endmodule

// ===== rtl/cubic_spline_point_evaluator_unit.sv =====
// Spline point evaluator: a load beat writes a 3-D control point; a query beat
// returns the position, the derivative or an approximate chord length of one
// linear, Catmull-Rom or cubic Bezier segment, or a range error. One item is
// in work at a time, and all products go through one shared 35x35 multiplier
// under a small sequencer, so the cost is set by the multiplier passes and by
// the point store's single read port. A load or an in-range query first
// reduces its address modulo MAX_POINTS by repeated subtraction; a load then
// ends. A position or derivative first forms t^2 and t^3 in the multiplier,
// then for each control point (two in linear mode, else four) forms the
// weight, reads the point and does three multiply-accumulates. A length query
// runs LENGTH_STEPS + 1 such evaluations (2 in linear mode) plus, per chord, a
// sum of squares and a bit-serial square root. A range error skips all of this
// and goes straight to the result. A finished result sits in an output
// register, so the next item is taken while it waits.
module cubic_spline_point_evaluator_unit #(
    parameter int MAX_POINTS   = 256,
    parameter int LENGTH_STEPS = 3
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  cspe_pkg::in_item_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output cspe_pkg::out_item_t m_data,
    input  logic                cfg_wr_en,
    input  logic [1:0]          cfg_index,
    input  logic [7:0]          cfg_wdata
);
    import cspe_pkg::*;

    cfg_t      cfg_reg;
    logic      m_valid_reg;
    out_item_t m_data_reg;
    logic      core_res_valid;
    logic      out_free;
    out_item_t core_res_item;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.curve_mode   <= MODE_CATMULL;
            cfg_reg.segment_low  <= '0;
            cfg_reg.segment_high <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_CURVE_MODE: cfg_reg.curve_mode   <= cfg_wdata[1:0];
                REG_SEG_LOW:    cfg_reg.segment_low  <= cfg_wdata;
                REG_SEG_HIGH:   cfg_reg.segment_high <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    cspe_core #(
        .MAX_POINTS   (MAX_POINTS),
        .LENGTH_STEPS (LENGTH_STEPS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_item   (s_data),
        .cfg       (cfg_reg),
        .res_valid (core_res_valid),
        .res_ready (out_free),
        .res_item  (core_res_item)
    );

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (core_res_valid && out_free) begin
            m_valid_reg <= 1'b1;
            m_data_reg  <= core_res_item;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // an accepted item keeps the unit busy for at least the next cycle
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input taken twice in a row");

    // an error beat carries nothing else
    a_error_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.range_error) |->
        (m_data.seg_length == 0 && m_data.out_x == 0 &&
         m_data.out_y == 0 && m_data.out_z == 0))
        else $error("error beat with payload");

    // a length beat has zero coordinates
    a_length_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.seg_length != 0) |->
        (m_data.out_x == 0 && m_data.out_y == 0 && m_data.out_z == 0))
        else $error("length beat with coordinates");

endmodule
